// ----- rtl/broadcast_stride_walker_assert.svh -----
// Assertion macros for the broadcast stride walker.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef BROADCAST_STRIDE_WALKER_ASSERT_SVH
`define BROADCAST_STRIDE_WALKER_ASSERT_SVH

// same-cycle implication
`define BSW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bsw: same-cycle check failed");

// next-cycle implication
`define BSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bsw: next-cycle check failed");

`endif

// ----- rtl/bsw_pkg.sv -----
// Shared constants and types for the broadcast stride walker.
// No dependencies.
package bsw_pkg;

    localparam int SLOTS        = 4;   // dimension slots in the register layout
    localparam int MAX_DIMS     = 4;   // innermost slots in use
    localparam int DIM_BITS     = 16;
    localparam int ADDR_BITS    = 32;
    localparam int SLOT_FIELD   = 16;  // slot width inside dim_sizes
    localparam int STRIDE_FIELD = 32;  // stride width inside a stride register
    localparam int CFG_BITS     = 64;
    localparam int CFG_IDX_BITS = 3;
    localparam int IN_BITS      = 8;
    localparam int OUT_BITS     = 3 * ADDR_BITS;

    typedef logic [DIM_BITS-1:0]  t_dim;
    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DIM_SIZES = 3'd0,
        REG_A_OUTER   = 3'd1,
        REG_A_INNER   = 3'd2,
        REG_B_OUTER   = 3'd3,
        REG_B_INNER   = 3'd4,
        REG_A_BASE    = 3'd5,
        REG_B_BASE    = 3'd6,
        REG_Y_BASE    = 3'd7
    } t_cfg_reg;

    // decoded configuration, slot 0 is outermost
    typedef struct packed {
        t_dim  [SLOTS-1:0] size;
        t_addr [SLOTS-1:0] a_stride;
        t_addr [SLOTS-1:0] b_stride;
        t_addr             a_base;
        t_addr             b_base;
        t_addr             y_base;
    } t_cfg;

    // one element handed from the odometer to the address pipeline
    typedef struct packed {
        t_dim [SLOTS-1:0] idx;
        t_addr            y_off;
        logic             last;
    } t_elem;

    typedef struct packed {
        logic emit;      // accepted step yields an element
        logic any_zero;  // some used size is zero
        logic done;      // registered walk-finished flag
    } t_odo_stat;

endpackage

// ----- rtl/broadcast_stride_walker.sv -----
// Broadcast stride walker: address generator for elementwise tensor ops.
// Input stream s_axis: tdata[0] = restart (1 starts a new walk at element
// zero, 0 steps to the next element). Each input transfer yields at most
// one output transfer on m_axis: a_address, b_address, y_address in tdata,
// tlast on the final element. A step with no walk active, or any used
// dimension size zero, yields no output.
// Configuration: one write per cycle on i_cfg_valid/i_cfg_index/i_cfg_data,
// always ready; write only while no transfer is in flight.
// Pipeline: an input transfer reaches output valid through the product stage,
// pair-sum stage and base-add output register. Throughput: one element per
// cycle while m_axis_tready stays high.
// Backpressure: with m_axis_tready low the three stages fill, then
// s_axis_tready drops until the output transfer completes.
// Reset: configuration registers go to zero, no walk is active, pipeline empties.
// Depends on bsw_pkg, bsw_cfg, bsw_odometer, bsw_addr_pipe.
`include "broadcast_stride_walker_assert.svh"

module broadcast_stride_walker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bsw_pkg::IN_BITS-1:0]      s_axis_tdata,  // [0] restart, rest zero
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bsw_pkg::OUT_BITS-1:0]     m_axis_tdata,  // a_address, b_address, y_address
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bsw_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [bsw_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import bsw_pkg::*;

    t_cfg      cfg;
    t_elem     elem;
    t_odo_stat stat;
    logic      in_xfer, restart;

    assign o_cfg_ready = 1'b1;
    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign restart     = s_axis_tdata[0];

    bsw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bsw_odometer u_odo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (in_xfer),
        .i_restart (restart),
        .i_size    (cfg.size),
        .o_elem    (elem),
        .o_stat    (stat)
    );

    bsw_addr_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_xfer && stat.emit),
        .o_ready (s_axis_tready),
        .i_elem  (elem),
        .i_cfg   (cfg),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    // a restart with all sizes nonzero always yields element zero
    `BSW_ASSERT_IMP(a_restart_emits, in_xfer && restart && !stat.any_zero, stat.emit)
    // the final element ends the walk
    `BSW_ASSERT_NEXT(a_last_ends_walk, in_xfer && stat.emit && elem.last, stat.done)
    // input is only held off by a stalled, full output
    `BSW_ASSERT_IMP(a_ready_only_on_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

// ----- rtl/bsw_cfg.sv -----
// Configuration register file and slot decode.
// Depends on bsw_pkg.
module bsw_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [bsw_pkg::CFG_IDX_BITS-1:0] i_index,
    input  logic [bsw_pkg::CFG_BITS-1:0]     i_data,
    output bsw_pkg::t_cfg                    o_cfg
);
    import bsw_pkg::*;

    logic [CFG_BITS-1:0] r_dim_sizes, r_a_outer, r_a_inner, r_b_outer, r_b_inner;
    t_addr               r_a_base, r_b_base, r_y_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_sizes <= '0;
            r_a_outer   <= '0;
            r_a_inner   <= '0;
            r_b_outer   <= '0;
            r_b_inner   <= '0;
            r_a_base    <= '0;
            r_b_base    <= '0;
            r_y_base    <= '0;
        end else if (i_wr) begin
            unique case (t_cfg_reg'(i_index))
                REG_DIM_SIZES: r_dim_sizes <= i_data;
                REG_A_OUTER:   r_a_outer   <= i_data;
                REG_A_INNER:   r_a_inner   <= i_data;
                REG_B_OUTER:   r_b_outer   <= i_data;
                REG_B_INNER:   r_b_inner   <= i_data;
                REG_A_BASE:    r_a_base    <= i_data[ADDR_BITS-1:0];
                REG_B_BASE:    r_b_base    <= i_data[ADDR_BITS-1:0];
                REG_Y_BASE:    r_y_base    <= i_data[ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // unused leading slots act as size 1, stride 0
    always_comb begin
        logic [CFG_BITS-1:0] wa, wb;
        o_cfg.a_base = r_a_base;
        o_cfg.b_base = r_b_base;
        o_cfg.y_base = r_y_base;
        for (int s = 0; s < SLOTS; s++) begin
            wa = (s < 2) ? r_a_outer : r_a_inner;
            wb = (s < 2) ? r_b_outer : r_b_inner;
            if (s >= SLOTS - MAX_DIMS) begin
                o_cfg.size[s] = r_dim_sizes[SLOT_FIELD*(SLOTS-1-s) +: DIM_BITS];
                o_cfg.a_stride[s] = (s % 2 == 1) ? wa[0 +: ADDR_BITS]
                                                 : wa[STRIDE_FIELD +: ADDR_BITS];
                o_cfg.b_stride[s] = (s % 2 == 1) ? wb[0 +: ADDR_BITS]
                                                 : wb[STRIDE_FIELD +: ADDR_BITS];
            end else begin
                o_cfg.size[s]     = t_dim'(1);
                o_cfg.a_stride[s] = '0;
                o_cfg.b_stride[s] = '0;
            end
        end
    end

endmodule

// ----- rtl/bsw_odometer.sv -----
// Walk state: per-dimension index counters, linear offset and done flag.
// Depends on bsw_pkg.
module bsw_odometer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_restart,
    input  bsw_pkg::t_dim [bsw_pkg::SLOTS-1:0] i_size,
    output bsw_pkg::t_elem           o_elem,
    output bsw_pkg::t_odo_stat       o_stat
);
    import bsw_pkg::*;

    t_dim [SLOTS-1:0] r_idx, n_idx, cur_idx;
    t_addr            r_y, n_y, cur_y;
    logic             r_done, n_done, cur_done;
    logic             any_zero, emit, carry;

    always_comb begin
        logic [DIM_BITS:0] nxt;
        cur_idx  = i_restart ? '0 : r_idx;
        cur_y    = i_restart ? '0 : r_y;
        cur_done = i_restart ? 1'b0 : r_done;

        any_zero = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            if (i_size[s] == '0) any_zero = 1'b1;
        end
        emit = !cur_done && !any_zero;

        // ripple from the innermost dimension; an index past its size wraps
        carry = 1'b1;
        n_idx = cur_idx;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            nxt = {1'b0, cur_idx[s]} + 1'b1;
            if (carry) begin
                if (nxt < {1'b0, i_size[s]}) begin
                    n_idx[s] = nxt[DIM_BITS-1:0];
                    carry    = 1'b0;
                end else begin
                    n_idx[s] = '0;
                end
            end
        end

        if (emit) begin
            n_y    = carry ? '0 : cur_y + 1'b1;
            n_done = carry;
        end else begin
            n_idx  = cur_idx;
            n_y    = cur_y;
            n_done = cur_done | any_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_y    <= '0;
            r_done <= 1'b1;
        end else if (i_step) begin
            r_idx  <= n_idx;
            r_y    <= n_y;
            r_done <= n_done;
        end
    end

    assign o_elem.idx      = cur_idx;
    assign o_elem.y_off    = cur_y;
    assign o_elem.last     = carry;
    assign o_stat.emit     = emit;
    assign o_stat.any_zero = any_zero;
    assign o_stat.done     = r_done;

endmodule

// ----- rtl/bsw_addr_pipe.sv -----
// Three-stage address pipeline: stride products, pair sums, base add and
// output register. Depends on bsw_pkg.
module bsw_addr_pipe (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  bsw_pkg::t_elem            i_elem,
    input  bsw_pkg::t_cfg             i_cfg,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [bsw_pkg::OUT_BITS-1:0] o_data,
    output logic                      o_last
);
    import bsw_pkg::*;

    logic en1, en2, en3;
    logic r1_v, r2_v, r3_v;

    t_addr [SLOTS-1:0] r1_pa, r1_pb;
    t_addr             r1_y;
    logic              r1_last;

    t_addr r2_a_lo, r2_a_hi, r2_b_lo, r2_b_hi, r2_y;
    logic  r2_last;

    t_addr r3_a, r3_b, r3_y;
    logic  r3_last;

    assign en3     = !r3_v || i_ready;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
        end
    end

    // index times stride, kept modulo the address width
    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int s = 0; s < SLOTS; s++) begin
                r1_pa[s] <= ADDR_BITS'(i_elem.idx[s]) * i_cfg.a_stride[s];
                r1_pb[s] <= ADDR_BITS'(i_elem.idx[s]) * i_cfg.b_stride[s];
            end
            r1_y    <= i_elem.y_off;
            r1_last <= i_elem.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_a_lo <= r1_pa[0] + r1_pa[1];
            r2_a_hi <= r1_pa[2] + r1_pa[3];
            r2_b_lo <= r1_pb[0] + r1_pb[1];
            r2_b_hi <= r1_pb[2] + r1_pb[3];
            r2_y    <= r1_y;
            r2_last <= r1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_a    <= i_cfg.a_base + r2_a_lo + r2_a_hi;
            r3_b    <= i_cfg.b_base + r2_b_lo + r2_b_hi;
            r3_y    <= i_cfg.y_base + r2_y;
            r3_last <= r2_last;
        end
    end

    assign o_valid = r3_v;
    assign o_data  = {r3_y, r3_b, r3_a};
    assign o_last  = r3_last;

endmodule

// ----- verif/broadcast_stride_walker_tb.sv -----
// Self-checking testbench for broadcast_stride_walker: stream stimulus, an odometer
// model of the walk, and a scoreboard on the output address stream.
// Depends on bsw_pkg and the broadcast_stride_walker RTL.
`timescale 1ns / 100ps

module broadcast_stride_walker_tb;
    import bsw_pkg::*;

    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_PHASE = 410;

    typedef struct packed {
        logic [ADDR_BITS-1:0] a_addr;
        logic [ADDR_BITS-1:0] b_addr;
        logic [ADDR_BITS-1:0] y_addr;
        logic                 last;
    } t_elem_addr;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_BITS-1:0]      s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b1;
    logic [OUT_BITS-1:0]     m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;

    // shadow of the register file and the walk state
    logic [CFG_BITS-1:0]  cfg_shadow [0:7];
    logic [DIM_BITS-1:0]  walk_idx [0:SLOTS-1];
    logic [ADDR_BITS-1:0] walk_y;
    bit                   walk_over;

    t_elem_addr pending_addrs [$];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         mismatch_count;
    int         fail_count;
    int         cycle_count;

    broadcast_stride_walker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- model ----------------

    function automatic logic [DIM_BITS-1:0] size_of(int s);
        return cfg_shadow[REG_DIM_SIZES][SLOT_FIELD*(SLOTS-1-s) +: DIM_BITS];
    endfunction

    function automatic logic [ADDR_BITS-1:0] stride_of(logic [CFG_BITS-1:0] outer,
                                                       logic [CFG_BITS-1:0] inner, int s);
        logic [CFG_BITS-1:0] w;
        w = (s < 2) ? outer : inner;
        return (s % 2 == 1) ? w[31:0] : w[63:32];
    endfunction

    function automatic longint walk_length();
        longint n;
        n = 1;
        for (int s = 0; s < SLOTS; s++)
            n = n * longint'(size_of(s));
        return n;
    endfunction

    function automatic bit advance_walk(input bit restart, output t_elem_addr e);
        logic [ADDR_BITS-1:0] ao, bo;
        logic [DIM_BITS:0]    nxt;
        bit                   carry;
        e = '0;
        if (restart) begin
            for (int s = 0; s < SLOTS; s++)
                walk_idx[s] = '0;
            walk_y = '0;
            walk_over = 1'b0;
        end
        if (walk_over)
            return 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            if (size_of(s) == 0) begin
                walk_over = 1'b1;
                return 1'b0;
            end
        end
        ao = '0;
        bo = '0;
        for (int s = 0; s < SLOTS; s++) begin
            ao = ao + ADDR_BITS'(walk_idx[s])
                 * stride_of(cfg_shadow[REG_A_OUTER], cfg_shadow[REG_A_INNER], s);
            bo = bo + ADDR_BITS'(walk_idx[s])
                 * stride_of(cfg_shadow[REG_B_OUTER], cfg_shadow[REG_B_INNER], s);
        end
        e.a_addr = cfg_shadow[REG_A_BASE][ADDR_BITS-1:0] + ao;
        e.b_addr = cfg_shadow[REG_B_BASE][ADDR_BITS-1:0] + bo;
        e.y_addr = cfg_shadow[REG_Y_BASE][ADDR_BITS-1:0] + walk_y;
        // odometer step; an index at or past a shrunken size wraps with carry
        carry = 1'b1;
        for (int s = SLOTS - 1; s >= 0 && carry; s--) begin
            nxt = {1'b0, walk_idx[s]} + 1'b1;
            if (nxt < {1'b0, size_of(s)}) begin
                walk_idx[s] = nxt[DIM_BITS-1:0];
                carry = 1'b0;
            end else begin
                walk_idx[s] = '0;
            end
        end
        walk_y = walk_y + 1'b1;
        if (carry) begin
            walk_over = 1'b1;
            walk_y = '0;
        end
        e.last = carry;
        return 1'b1;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_step(input bit restart, output bit produced);
        t_elem_addr e;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_BITS-1){1'b0}}, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        produced = advance_walk(restart, e);
        if (produced)
            pending_addrs.push_back(e);
    endtask

    task automatic send_steps(input bit restart, input int n, inout int produced_count);
        bit produced;
        for (int i = 0; i < n; i++) begin
            send_step(restart, produced);
            produced_count += produced;
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_shadow[idx] = data;
    endtask

    task automatic cfg_done();
        i_cfg_valid <= 1'b0;
    endtask

    // block drained: no result owed, and ignored steps given time to retire
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_addrs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DIM_BITS-1:0] pick_size();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2)
            return DIM_BITS'($urandom);
        return DIM_BITS'($urandom_range(1, 4));
    endfunction

    function automatic logic [31:0] pick_stride();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return $urandom_range(0, 8);
            2: return -$urandom_range(1, 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_base();
        case ($urandom_range(0, 5))
            0: return {$urandom, 32'h0000_0000};
            1: return {$urandom, 32'hFFFF_FFFF};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic randomize_config();
        write_reg(REG_DIM_SIZES, {pick_size(), pick_size(), pick_size(), pick_size()});
        write_reg(REG_A_OUTER, {pick_stride(), pick_stride()});
        write_reg(REG_A_INNER, {pick_stride(), pick_stride()});
        write_reg(REG_B_OUTER, {pick_stride(), pick_stride()});
        write_reg(REG_B_INNER, {pick_stride(), pick_stride()});
        write_reg(REG_A_BASE, pick_base());
        write_reg(REG_B_BASE, pick_base());
        write_reg(REG_Y_BASE, pick_base());
        cfg_done();
    endtask

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        t_elem_addr e;
        t_elem_addr got;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.a_addr = m_axis_tdata[ADDR_BITS-1:0];
            got.b_addr = m_axis_tdata[2*ADDR_BITS-1:ADDR_BITS];
            got.y_addr = m_axis_tdata[3*ADDR_BITS-1:2*ADDR_BITS];
            got.last   = m_axis_tlast;
            if (pending_addrs.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: a %h b %h y %h last %b",
                             got.a_addr, got.b_addr, got.y_addr, got.last);
            end else begin
                e = pending_addrs.pop_front();
                if (got.a_addr !== e.a_addr || got.b_addr !== e.b_addr ||
                    got.y_addr !== e.y_addr || got.last !== e.last) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp a %h b %h y %h last %b, got a %h b %h y %h last %b",
                                 e.a_addr, e.b_addr, e.y_addr, e.last,
                                 got.a_addr, got.b_addr, got.y_addr, got.last);
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_basic_walk();
        int n;
        n = 0;
        wait_idle();
        write_reg(REG_DIM_SIZES, {16'd2, 16'd1, 16'd3, 16'd1});
        write_reg(REG_A_OUTER, {32'hFFFF_FFF0, 32'd7});
        write_reg(REG_A_INNER, {32'd5, 32'd1});
        write_reg(REG_B_OUTER, {32'd0, 32'd0});
        write_reg(REG_B_INNER, {32'd1, 32'd0});
        write_reg(REG_A_BASE, 64'hFFFF_FFFF_FFFF_FFF8);
        write_reg(REG_B_BASE, 64'h0000_0000_0000_1000);
        write_reg(REG_Y_BASE, 64'h1234_5678_FFFF_FFFC);
        cfg_done();
        send_steps(1'b1, 1, n);
        // five more elements, then one step past the end
        send_steps(1'b0, 6, n);
    endtask

    task automatic test_edge_shapes();
        int n;
        n = 0;
        wait_idle();
        // single-element tensor with all-ones bases
        write_reg(REG_DIM_SIZES, {16'd1, 16'd1, 16'd1, 16'd1});
        write_reg(REG_A_BASE, '1);
        write_reg(REG_B_BASE, '1);
        write_reg(REG_Y_BASE, '1);
        cfg_done();
        send_steps(1'b1, 1, n);
        send_steps(1'b0, 1, n);
        wait_idle();
        // zero size: restart yields nothing
        write_reg(REG_DIM_SIZES, {16'd1, 16'd0, 16'd1, 16'd1});
        cfg_done();
        send_steps(1'b1, 1, n);
        send_steps(1'b0, 1, n);
    endtask

    task automatic test_large_dims();
        int n;
        n = 0;
        wait_idle();
        write_reg(REG_DIM_SIZES, {16'hFFFF, 16'd1, 16'd1, 16'hFFFF});
        write_reg(REG_A_OUTER, '1);
        write_reg(REG_A_INNER, '1);
        write_reg(REG_B_OUTER, {32'h8000_0000, 32'h8000_0000});
        write_reg(REG_B_INNER, {32'h8000_0000, 32'h8000_0000});
        cfg_done();
        send_steps(1'b1, 1, n);
        send_steps(1'b0, 2, n);
    endtask

    task automatic test_reconfig_midwalk();
        int n;
        n = 0;
        wait_idle();
        write_reg(REG_DIM_SIZES, {16'd1, 16'd1, 16'd4, 16'd8});
        write_reg(REG_A_INNER, {32'd8, 32'd1});
        write_reg(REG_B_INNER, {32'd1, 32'd0});
        cfg_done();
        send_steps(1'b1, 1, n);
        send_steps(1'b0, 5, n);
        wait_idle();
        // inner index now past the new size: wraps with carry
        write_reg(REG_DIM_SIZES, {16'd1, 16'd1, 16'd4, 16'd3});
        cfg_done();
        send_steps(1'b0, 3, n);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int     produced_count;
        int     sent_count;
        int     burst_end;
        int     n_adv;
        longint total;
        int     cap;
        bit     produced;
        produced_count = 0;
        sent_count     = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent_count < n_items) begin
            wait_idle();
            randomize_config();
            total = walk_length();
            cap = (total > 40) ? 40 : int'(total);
            burst_end = sent_count + int'($urandom_range(20, 70));
            for (int k = 0; k < 200 && sent_count < burst_end; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: lone step of either kind
                    send_step(1'($urandom_range(0, 1)), produced);
                    produced_count += produced;
                    sent_count++;
                end else begin
                    n_adv = int'($urandom_range(0, cap + 1));
                    send_steps(1'b1, 1, produced_count);
                    send_steps(1'b0, n_adv, produced_count);
                    sent_count += 1 + n_adv;
                end
            end
        end
    endtask

    initial begin
        int leftover;
        for (int i = 0; i < 8; i++)
            cfg_shadow[i] = '0;
        for (int s = 0; s < SLOTS; s++)
            walk_idx[s] = '0;
        walk_y         = '0;
        walk_over      = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        fail_count     = 0;
        cycle_count    = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_walk();
        test_edge_shapes();
        test_large_dims();
        test_reconfig_midwalk();
        test_random_traffic(0, 0, ITEMS_PER_PHASE);
        test_random_traffic(46, 0, ITEMS_PER_PHASE);
        test_random_traffic(0, 46, ITEMS_PER_PHASE);
        test_random_traffic(22, 22, ITEMS_PER_PHASE);

        wait_idle();
        leftover = pending_addrs.size();
        fail_count += leftover;
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- broadcast_stride_walker.f -----
+incdir+rtl
rtl/bsw_pkg.sv
rtl/bsw_cfg.sv
rtl/bsw_odometer.sv
rtl/bsw_addr_pipe.sv
rtl/broadcast_stride_walker.sv
verif/broadcast_stride_walker_tb.sv
